@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the decimator RTL. Synthesis builds see empty
// bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset
`define PDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true out of reset
`define PDA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define PDA_ASSERT(label, clk, rst_n, prop, msg)
`define PDA_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ hdl/pda_pkg.sv @@
// ----------------------------------------------------------------------------
// pda_pkg
// Types and constants for the pixel decimator with character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package pda_pkg;

    // Default geometry limit, symbol table size and queue depth
    localparam int MAX_DIM_DEF = 4096;
    localparam int MAX_SYMBOLS = 8;
    localparam int FIFO_DEPTH  = 4;

    // Register field widths
    localparam int DIM_W  = 13;
    localparam int QS_W   = 8;
    localparam int NSYM_W = 4;
    localparam int TBL_W  = 64;
    localparam int PIX_W  = 8;
    localparam int SYM_W  = 8;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 3;

    // Register indexes
    localparam logic [ADDR_W-1:0] REG_IN_COLS      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COL_STEP     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ROW_STEP     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_OUT_COLS     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_OUT_ROWS     = 3'd4;
    localparam logic [ADDR_W-1:0] REG_QUANT_STEP   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_NUM_SYMBOLS  = 3'd6;
    localparam logic [ADDR_W-1:0] REG_SYMBOL_TABLE = 3'd7;

    // Configuration register file
    typedef struct packed {
        logic [DIM_W-1:0]  in_cols;
        logic [DIM_W-1:0]  col_step;
        logic [DIM_W-1:0]  row_step;
        logic [DIM_W-1:0]  out_cols;
        logic [DIM_W-1:0]  out_rows;
        logic [QS_W-1:0]   quant_step;
        logic [NSYM_W-1:0] num_symbols;
        logic [TBL_W-1:0]  symbol_table;
    } cfg_t;

    // Kept pixel queued between front and back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             line_end;
        logic             frame_end;
    } dec_item_t;

endpackage

`default_nettype wire

@@ hdl/pda_front.sv @@
// ----------------------------------------------------------------------------
// pda_front
// Raster counters: decides which pixels are kept and tags line/frame ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pda_front #(
    parameter int MAX_DIM = pda_pkg::MAX_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pda_pkg::cfg_t                  cfg,
    input  wire logic                           in_accept,
    input  wire logic [pda_pkg::PIX_W-1:0]      pixel,
    input  wire logic                           frame_start,
    output logic                                push,
    output pda_pkg::dec_item_t                  push_item
);
    import pda_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int EFF_W = IDX_W + 1;
    localparam int SUM_W = EFF_W + 1;

    // Clamp a geometry register to 1..MAX_DIM
    function automatic logic [EFF_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
        logic [EFF_W-1:0] r;
        if (v == '0)
            r = EFF_W'(1);
        else if (32'(v) > MAX_DIM)
            r = EFF_W'(MAX_DIM);
        else
            r = EFF_W'(v);
        return r;
    endfunction

    logic [IDX_W-1:0] in_col_reg, in_col_next;
    logic [IDX_W-1:0] col_phase_reg, col_phase_next;
    logic [IDX_W-1:0] row_phase_reg, row_phase_next;
    logic [EFF_W-1:0] out_col_reg, out_col_next;
    logic [EFF_W-1:0] out_row_reg, out_row_next;
    logic             done_reg, done_next;

    logic [EFF_W-1:0] cols, cstep, rstep, ocols, orows;
    logic [IDX_W-1:0] icc, cph, rph;
    logic [EFF_W-1:0] occ, orc, occ_kept;
    logic             done_cur, keep, line_last, frame_last, row_end;

    assign cols  = dim_eff(cfg.in_cols);
    assign cstep = dim_eff(cfg.col_step);
    assign rstep = dim_eff(cfg.row_step);
    assign ocols = dim_eff(cfg.out_cols);
    assign orows = dim_eff(cfg.out_rows);

    // Frame start clears counters before the pixel is looked at
    assign icc      = frame_start ? '0 : in_col_reg;
    assign cph      = frame_start ? '0 : col_phase_reg;
    assign rph      = frame_start ? '0 : row_phase_reg;
    assign occ      = frame_start ? '0 : out_col_reg;
    assign orc      = frame_start ? '0 : out_row_reg;
    assign done_cur = frame_start ? 1'b0 : done_reg;

    // Keep decision and end-of-line / end-of-frame tags
    assign keep = !done_cur && (rph == '0) && (cph == '0) &&
                  (occ < ocols) && (orc < orows);
    assign line_last = (SUM_W'(occ) + SUM_W'(1) >= SUM_W'(ocols)) ||
                       (SUM_W'(icc) + SUM_W'(cstep) >= SUM_W'(cols));
    assign frame_last = line_last && (SUM_W'(orc) + SUM_W'(1) >= SUM_W'(orows));
    assign row_end  = SUM_W'(icc) + SUM_W'(1) >= SUM_W'(cols);
    assign occ_kept = keep ? occ + EFF_W'(1) : occ;

    assign push               = in_accept && keep;
    assign push_item.pixel     = pixel;
    assign push_item.line_end  = line_last;
    assign push_item.frame_end = frame_last;

    // Counter update
    always_comb
    begin
        in_col_next    = in_col_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        done_next      = done_reg;
        if (in_accept) begin
            in_col_next    = icc;
            col_phase_next = cph;
            row_phase_next = rph;
            out_col_next   = occ;
            out_row_next   = orc;
            done_next      = done_cur;
            if (!done_cur) begin
                done_next = keep && frame_last;
                if (row_end) begin
                    if ((rph == '0) && (orc < orows))
                        out_row_next = orc + EFF_W'(1);
                    in_col_next    = '0;
                    col_phase_next = '0;
                    out_col_next   = '0;
                    row_phase_next = (SUM_W'(rph) + SUM_W'(1) >= SUM_W'(rstep)) ?
                                     '0 : rph + IDX_W'(1);
                end else begin
                    in_col_next    = icc + IDX_W'(1);
                    out_col_next   = occ_kept;
                    col_phase_next = (SUM_W'(cph) + SUM_W'(1) >= SUM_W'(cstep)) ?
                                     '0 : cph + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_col_reg    <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            done_reg      <= 1'b0;
        end else begin
            in_col_reg    <= in_col_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            done_reg      <= done_next;
        end
    end

    // A frame_end tag closes the frame until the next frame start
    `PDA_ASSERT(a_frame_close, clk, rst_n, push && frame_last |=> done_reg, "frame not closed")
    // Nothing is kept once the frame is closed
    `PDA_NEVER(a_keep_after_done, clk, rst_n, push && done_reg && !frame_start, "kept after done")

endmodule

`default_nettype wire

@@ hdl/pda_fifo.sv @@
// ----------------------------------------------------------------------------
// pda_fifo
// Small register queue between the counter front and the mapping back.
// ----------------------------------------------------------------------------
`default_nettype none

module pda_fifo #(
    parameter int DEPTH = pda_pkg::FIFO_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire pda_pkg::dec_item_t  push_item,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output pda_pkg::dec_item_t       head
);
    import pda_pkg::*;

    `include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dec_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    `PDA_NEVER(a_overflow, clk, rst_n, push && full, "queue overflow")
    `PDA_NEVER(a_underflow, clk, rst_n, pop && !not_empty, "queue underflow")

endmodule

`default_nettype wire

@@ hdl/pda_back.sv @@
// ----------------------------------------------------------------------------
// pda_back
// Gray level to character mapping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pda_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pda_pkg::cfg_t               cfg,
    input  wire logic                        head_valid,
    input  wire pda_pkg::dec_item_t          head,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pda_pkg::SYM_W-1:0]        out_symbol,
    output logic                             out_line_end,
    output logic                             out_frame_end
);
    import pda_pkg::*;

    `include "assert_macros.svh"

    localparam int SEL_W = $clog2(MAX_SYMBOLS);
    localparam int THR_W = QS_W + SEL_W + 1;

    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] symbol_reg;
    logic             line_end_reg, frame_end_reg;

    logic [NSYM_W-1:0]  n_eff;
    logic [SEL_W-1:0]   sel;
    logic [SYM_W-1:0]   symbol_next;

    // Number of symbols in use, clamped to 1..MAX_SYMBOLS
    always_comb
    begin
        if (cfg.num_symbols == '0)
            n_eff = NSYM_W'(1);
        else if (cfg.num_symbols > NSYM_W'(MAX_SYMBOLS))
            n_eff = NSYM_W'(MAX_SYMBOLS);
        else
            n_eff = cfg.num_symbols;
    end

    // Threshold compares, first hit wins, else last symbol in use
    always_comb
    begin
        logic [THR_W-1:0] thr;
        sel = SEL_W'(n_eff - NSYM_W'(1));
        for (int k = MAX_SYMBOLS - 2; k >= 0; k--) begin
            thr = THR_W'(cfg.quant_step) * THR_W'(k + 1);
            if ((NSYM_W'(k + 1) < n_eff) && (THR_W'(head.pixel) <= thr))
                sel = SEL_W'(k);
        end
    end

    assign symbol_next = cfg.symbol_table[SYM_W*sel +: SYM_W];

    // Output register refills from the queue head whenever empty or being taken
    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            symbol_reg    <= symbol_next;
            line_end_reg  <= head.line_end;
            frame_end_reg <= head.frame_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_symbol    = symbol_reg;
    assign out_line_end  = line_end_reg;
    assign out_frame_end = frame_end_reg;

    // The last character of a frame also ends its line
    `PDA_NEVER(a_frame_line, clk, rst_n, out_valid_reg && frame_end_reg && !line_end_reg, "frame_end without line_end")

endmodule

`default_nettype wire

@@ hdl/pixel_decimate_to_ascii_top.sv @@
// ----------------------------------------------------------------------------
// pixel_decimate_to_ascii_top
// Gray pixel decimator that turns kept pixels into character codes.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on s_axis in raster order, one transaction per pixel;
//   tuser set marks the first pixel of a frame and clears all counters.
//   Every col_step-th column of every row_step-th row is kept, up to
//   out_cols per line and out_rows lines. Each kept pixel leaves on m_axis
//   as a character code, tlast on the last character of a line and tuser on
//   the last character of the frame; later pixels are dropped until the
//   next frame start.
//   Throughput is one pixel per clock while the queue is not full. A kept
//   pixel passes the queue stage and then the output register to m_axis.
//   A four-entry queue between the counter front and the mapping back
//   absorbs receiver stalls; s_axis_tready drops only when it is full.
//   Reset empties the queue and the output register and clears counters;
//   registers return to 640, 1, 1, 80, 40, 32, 8 and an all-zero table.
//   Write registers through cfg_we/cfg_addr/cfg_wdata only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_decimate_to_ascii_top #(
    parameter int MAX_DIM = pda_pkg::MAX_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [pda_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [pda_pkg::CFG_W-1:0]     cfg_wdata,
    // Pixel input
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [pda_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
    input  wire logic                          s_axis_tuser,   // [0] frame_start
    // Character output
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [pda_pkg::SYM_W-1:0]          m_axis_tdata,   // [7:0] symbol
    output logic                               m_axis_tlast,   // line_end
    output logic                               m_axis_tuser    // [0] frame_end
);
    import pda_pkg::*;

    cfg_t      cfg_reg;
    logic      in_accept, push, pop, q_full, q_valid;
    dec_item_t push_item, head;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.in_cols      <= DIM_W'(640);
            cfg_reg.col_step     <= DIM_W'(1);
            cfg_reg.row_step     <= DIM_W'(1);
            cfg_reg.out_cols     <= DIM_W'(80);
            cfg_reg.out_rows     <= DIM_W'(40);
            cfg_reg.quant_step   <= QS_W'(32);
            cfg_reg.num_symbols  <= NSYM_W'(8);
            cfg_reg.symbol_table <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IN_COLS:      cfg_reg.in_cols      <= cfg_wdata[DIM_W-1:0];
                REG_COL_STEP:     cfg_reg.col_step     <= cfg_wdata[DIM_W-1:0];
                REG_ROW_STEP:     cfg_reg.row_step     <= cfg_wdata[DIM_W-1:0];
                REG_OUT_COLS:     cfg_reg.out_cols     <= cfg_wdata[DIM_W-1:0];
                REG_OUT_ROWS:     cfg_reg.out_rows     <= cfg_wdata[DIM_W-1:0];
                REG_QUANT_STEP:   cfg_reg.quant_step   <= cfg_wdata[QS_W-1:0];
                REG_NUM_SYMBOLS:  cfg_reg.num_symbols  <= cfg_wdata[NSYM_W-1:0];
                REG_SYMBOL_TABLE: cfg_reg.symbol_table <= cfg_wdata[TBL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && !q_full;

    pda_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_accept   (in_accept),
        .pixel       (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .push_item   (push_item)
    );

    pda_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    pda_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_symbol    (m_axis_tdata),
        .out_line_end  (m_axis_tlast),
        .out_frame_end (m_axis_tuser)
    );

endmodule

`default_nettype wire
